[hw/rtl/kabf_pkg.sv]
// Shared types, constants and helpers for the angle/bias Kalman filter.
`default_nettype none

package kabf_pkg;

    // Fractional bits of the Q8.24 covariance and gain words
    localparam int QSHIFT = 24;

    // Register reset values
    localparam logic [23:0] PERIOD_RST = 24'd83886;
    localparam logic [30:0] ANOISE_RST = 31'd16777;
    localparam logic [30:0] BNOISE_RST = 31'd83886;
    localparam logic [30:0] MNOISE_RST = 31'd8388608;
    localparam logic signed [31:0] ONE_Q24 = 32'sd16777216;

    // Register map, word index
    typedef enum logic [1:0] {
        REG_PERIOD = 2'd0,
        REG_ANOISE = 2'd1,
        REG_BNOISE = 2'd2,
        REG_MNOISE = 2'd3
    } t_reg_idx;

    // Multiply request: result is round(a*b / 2^24), ties away from zero
    typedef struct packed {
        logic               start;
        logic signed [34:0] a;
        logic signed [32:0] b;
    } t_mul_req;

    // Divide request: result is sat32((num << 24) / den), truncated
    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic signed [33:0] den;
    } t_div_req;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [45:0] v);
        logic signed [31:0] r;
        if (v > 46'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -46'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/kabf_mul.sv]
// Shared signed Q24 multiplier: two 34x16 partial products, accumulated in turn, then rounding.
`default_nettype none

module kabf_mul (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire kabf_pkg::t_mul_req i_req,
    output logic                   o_done,
    output logic signed [43:0]     o_res
);

    localparam int QSHIFT_L = kabf_pkg::QSHIFT;

    logic [1:0]         r_cnt;
    logic               r_done;
    logic [33:0]        r_ma;
    logic [31:0]        r_mb;
    logic               r_neg;
    logic [65:0]        r_acc;
    logic signed [43:0] r_res;

    logic [34:0] w_na;
    logic [32:0] w_nb;
    logic [33:0] w_ma;
    logic [31:0] w_mb;
    logic [43:0] w_rnd;
    logic [49:0] w_pp_lo;
    logic [49:0] w_pp_hi;

    // Operand magnitudes
    assign w_na  = -i_req.a;
    assign w_nb  = -i_req.b;
    assign w_ma  = i_req.a[34] ? w_na[33:0] : i_req.a[33:0];
    assign w_mb  = i_req.b[32] ? w_nb[31:0] : i_req.b[31:0];
    assign w_rnd = 44'(r_acc[65:QSHIFT_L]) + 44'(r_acc[QSHIFT_L-1]);

    // Partial products, full width
    assign w_pp_lo = 50'(r_ma) * 50'(r_mb[15:0]);
    assign w_pp_hi = 50'(r_ma) * 50'(r_mb[31:16]);

    // Cycle counter: 0 idle, 1 low half, 2 high half, 3 round
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_cnt)
                2'd0: if (i_req.start) r_cnt <= 2'd1;
                2'd1: r_cnt <= 2'd2;
                2'd2: r_cnt <= 2'd3;
                default: begin
                    r_cnt  <= 2'd0;
                    r_done <= 1'b1;
                end
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (r_cnt == 2'd0 && i_req.start) begin
            r_ma  <= w_ma;
            r_mb  <= w_mb;
            r_neg <= i_req.a[34] ^ i_req.b[32];
        end
        if (r_cnt == 2'd1) begin
            r_acc <= 66'(w_pp_lo);
        end
        if (r_cnt == 2'd2) begin
            r_acc <= r_acc + {w_pp_hi, 16'b0};
        end
        if (r_cnt == 2'd3) begin
            r_res <= r_neg ? -$signed(w_rnd) : $signed(w_rnd);
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

[hw/rtl/kabf_div.sv]
// Shared restoring divider for the gains: one quotient bit per cycle, saturated.
`default_nettype none

module kabf_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire kabf_pkg::t_div_req i_req,
    output logic                   o_done,
    output logic signed [31:0]     o_quo
);

    logic               r_busy;
    logic               r_done;
    logic [5:0]         r_cnt;
    logic [32:0]        r_rem;
    logic [31:0]        r_sh;
    logic [31:0]        r_q;
    logic [32:0]        r_den;
    logic               r_neg;
    logic               r_ovf;
    logic signed [31:0] r_quo;

    logic [31:0] w_nnum;
    logic [33:0] w_nden;
    logic [31:0] w_mnum;
    logic [32:0] w_mden;
    logic        w_ovf;
    logic [33:0] w_trial;
    logic        w_ge;
    logic [33:0] w_diff;
    logic [31:0] w_qf;

    // Magnitudes; a quotient of 2^32 or more only needs saturation
    assign w_nnum  = -i_req.num;
    assign w_nden  = -i_req.den;
    assign w_mnum  = i_req.num[31] ? w_nnum : i_req.num;
    assign w_mden  = i_req.den[33] ? w_nden[32:0] : i_req.den[32:0];
    assign w_ovf   = {9'b0, w_mnum} >= {w_mden, 8'b0};

    // One restoring step
    assign w_trial = {r_rem, r_sh[31]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_qf    = r_ovf ? 32'hFFFFFFFF : r_q;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_req.start) begin
                    r_busy <= 1'b1;
                    r_cnt  <= w_ovf ? 6'd0 : 6'd32;
                end
            end else if (r_cnt == 6'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.start) begin
            r_rem <= 33'(w_mnum[31:8]);
            r_sh  <= {w_mnum[7:0], 24'b0};
            r_q   <= 32'd0;
            r_den <= w_mden;
            r_neg <= i_req.num[31] ^ i_req.den[33];
            r_ovf <= w_ovf;
        end else if (r_busy && r_cnt != 6'd0) begin
            r_rem <= w_ge ? w_diff[32:0] : w_trial[32:0];
            r_sh  <= {r_sh[30:0], 1'b0};
            r_q   <= {r_q[30:0], w_ge};
        end else if (r_busy) begin
            if (r_neg) begin
                r_quo <= (w_qf > 32'h80000000) ? 32'sh80000000 : $signed(-w_qf);
            end else begin
                r_quo <= (w_qf > 32'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(w_qf);
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

[hw/rtl/kalman_angle_bias_filter.sv]
// Two-state angle/gyro-bias Kalman filter: sequencer, state and register port.
// A sample's result enters the output register after the sequencer has run
// ten multiply steps on the shared multiplier, two gain divisions on the shared
// bit-serial divider (each finishing early when the quotient saturates) and the
// step that loads the result. With zero innovation variance the divisions are
// skipped. Input is taken only while the sequencer is idle, so a new sample can
// be taken in the cycle after the result is loaded; a finished result waits in
// an output register, and the sequencer holds in its final step while an earlier
// result is still unaccepted. Configuration is written through the APB port at
// byte addresses 0 (period), 4 (angle noise), 8 (bias noise), 12 (meas. noise).
`default_nettype none

module kalman_angle_bias_filter (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [31:0] i_measured_angle,
    input  wire logic signed [31:0] i_gyro_rate,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_angle_estimate,
    output logic signed [31:0]      o_rate_estimate,
    output logic signed [31:0]      o_bias_estimate,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_ANG, S_N00, S_N01, S_N11, S_DIV0, S_DIV1,
        S_P00, S_P01, S_P10, S_P11, S_ANGC, S_BIAS, S_DONE
    } t_step;

    t_step r_step;
    logic  r_wait;

    // Configuration
    logic [23:0] r_period;
    logic [30:0] r_anoise;
    logic [30:0] r_bnoise;
    logic [30:0] r_mnoise;

    // Filter state and per-sample scratch
    logic signed [31:0] r_angle, r_bias, r_p00, r_p01, r_p10, r_p11;
    logic signed [31:0] r_meas, r_gyro, r_ang, r_n00, r_n01, r_n10, r_n11, r_k0, r_k1;

    // Output register
    logic               r_out_valid;
    logic signed [31:0] r_out_angle, r_out_rate, r_out_bias;

    kabf_pkg::t_mul_req w_mreq;
    kabf_pkg::t_div_req w_dreq;
    logic               w_mdone, w_ddone;
    logic signed [43:0] w_mres;
    logic signed [31:0] w_quo;
    logic signed [31:0] w_c;
    logic signed [31:0] w_sum;
    logic signed [31:0] w_sum10;
    logic signed [33:0] w_e;
    logic signed [32:0] w_err;
    logic               w_is_mul;
    logic               w_cfg_wr;
    logic               w_out_free;

    kabf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_done  (w_mdone),
        .o_res   (w_mres)
    );

    kabf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_done  (w_ddone),
        .o_quo   (w_quo)
    );

    assign w_e    = 34'(signed'({1'b0, r_mnoise})) + 34'(r_n00);
    assign w_err  = 33'(r_meas) - 33'(r_ang);
    assign w_is_mul = (r_step != S_IDLE) && (r_step != S_DIV0) &&
                      (r_step != S_DIV1) && (r_step != S_DONE);

    // Operand select for the shared multiplier: result is c + mulq(a, b)
    always_comb begin
        w_mreq.start = w_is_mul && !r_wait;
        w_mreq.a     = 35'sd0;
        w_mreq.b     = 33'(signed'({1'b0, r_period}));
        w_c          = 32'sd0;
        unique case (r_step)
            S_ANG: begin
                w_mreq.a = 35'(r_gyro) - 35'(r_bias);
                w_c      = r_angle;
            end
            S_N00: begin
                w_mreq.a = 35'(signed'({1'b0, r_anoise})) - 35'(r_p01) - 35'(r_p10);
                w_c      = r_p00;
            end
            S_N01: begin
                w_mreq.a = -35'(r_p11);
                w_c      = r_p01;
            end
            S_N11: begin
                w_mreq.a = 35'(signed'({1'b0, r_bnoise}));
                w_c      = r_p11;
            end
            S_P00: begin
                w_mreq.a = -35'(r_n00);
                w_mreq.b = 33'(r_k0);
                w_c      = r_n00;
            end
            S_P01: begin
                w_mreq.a = -35'(r_n01);
                w_mreq.b = 33'(r_k0);
                w_c      = r_n01;
            end
            S_P10: begin
                w_mreq.a = -35'(r_n00);
                w_mreq.b = 33'(r_k1);
                w_c      = r_n10;
            end
            S_P11: begin
                w_mreq.a = -35'(r_n01);
                w_mreq.b = 33'(r_k1);
                w_c      = r_n11;
            end
            S_ANGC: begin
                w_mreq.a = 35'(w_err);
                w_mreq.b = 33'(r_k0);
                w_c      = r_ang;
            end
            S_BIAS: begin
                w_mreq.a = 35'(w_err);
                w_mreq.b = 33'(r_k1);
                w_c      = r_bias;
            end
            default: begin
                w_mreq.a = 35'sd0;
            end
        endcase
    end

    assign w_sum   = kabf_pkg::sat32(46'(w_c) + 46'(w_mres));
    assign w_sum10 = kabf_pkg::sat32(46'(r_p10) + 46'(w_mres));

    // Divider request
    assign w_dreq.start = ((r_step == S_DIV0) || (r_step == S_DIV1)) && !r_wait;
    assign w_dreq.num   = (r_step == S_DIV1) ? r_n10 : r_n00;
    assign w_dreq.den   = w_e;

    assign w_cfg_wr   = psel && penable && pwrite;
    assign w_out_free = !r_out_valid || i_ready;

    // Sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
            r_period    <= kabf_pkg::PERIOD_RST;
            r_anoise    <= kabf_pkg::ANOISE_RST;
            r_bnoise    <= kabf_pkg::BNOISE_RST;
            r_mnoise    <= kabf_pkg::MNOISE_RST;
            r_angle     <= 32'sd0;
            r_bias      <= 32'sd0;
            r_p00       <= kabf_pkg::ONE_Q24;
            r_p01       <= 32'sd0;
            r_p10       <= 32'sd0;
            r_p11       <= kabf_pkg::ONE_Q24;
        end else begin
            // Register writes
            if (w_cfg_wr) begin
                unique case (kabf_pkg::t_reg_idx'(paddr[3:2]))
                    kabf_pkg::REG_PERIOD: r_period <= pwdata[23:0];
                    kabf_pkg::REG_ANOISE: r_anoise <= pwdata[30:0];
                    kabf_pkg::REG_BNOISE: r_bnoise <= pwdata[30:0];
                    kabf_pkg::REG_MNOISE: r_mnoise <= pwdata[30:0];
                endcase
            end

            // Result register empties unless the final step reloads it
            if (o_valid && i_ready && (r_step != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            // Issue a request, then wait for the unit
            if ((w_mreq.start || w_dreq.start)) begin
                r_wait <= 1'b1;
            end
            if (w_mdone || w_ddone) begin
                r_wait <= 1'b0;
            end

            unique case (r_step)
                S_IDLE: begin
                    if (i_valid) begin
                        r_meas <= i_measured_angle;
                        r_gyro <= i_gyro_rate;
                        r_step <= S_ANG;
                    end
                end
                S_ANG: if (w_mdone) begin
                    r_ang  <= w_sum;
                    r_step <= S_N00;
                end
                S_N00: if (w_mdone) begin
                    r_n00  <= w_sum;
                    r_step <= S_N01;
                end
                S_N01: if (w_mdone) begin
                    r_n01  <= w_sum;
                    r_n10  <= w_sum10;
                    r_step <= S_N11;
                end
                S_N11: if (w_mdone) begin
                    r_n11 <= w_sum;
                    if (w_e == 34'sd0) begin
                        r_k0   <= 32'sd0;
                        r_k1   <= 32'sd0;
                        r_step <= S_P00;
                    end else begin
                        r_step <= S_DIV0;
                    end
                end
                S_DIV0: if (w_ddone) begin
                    r_k0   <= w_quo;
                    r_step <= S_DIV1;
                end
                S_DIV1: if (w_ddone) begin
                    r_k1   <= w_quo;
                    r_step <= S_P00;
                end
                S_P00: if (w_mdone) begin
                    r_p00  <= w_sum;
                    r_step <= S_P01;
                end
                S_P01: if (w_mdone) begin
                    r_p01  <= w_sum;
                    r_step <= S_P10;
                end
                S_P10: if (w_mdone) begin
                    r_p10  <= w_sum;
                    r_step <= S_P11;
                end
                S_P11: if (w_mdone) begin
                    r_p11  <= w_sum;
                    r_step <= S_ANGC;
                end
                S_ANGC: if (w_mdone) begin
                    r_angle <= w_sum;
                    r_step  <= S_BIAS;
                end
                S_BIAS: if (w_mdone) begin
                    r_bias <= w_sum;
                    r_step <= S_DONE;
                end
                S_DONE: if (w_out_free) begin
                    r_out_valid <= 1'b1;
                    r_out_angle <= r_angle;
                    r_out_bias  <= r_bias;
                    r_out_rate  <= kabf_pkg::sat32(46'(r_gyro) - 46'(r_bias));
                    r_step      <= S_IDLE;
                end
                default: r_step <= S_IDLE;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (kabf_pkg::t_reg_idx'(paddr[3:2]))
            kabf_pkg::REG_PERIOD: prdata = {8'b0, r_period};
            kabf_pkg::REG_ANOISE: prdata = {1'b0, r_anoise};
            kabf_pkg::REG_BNOISE: prdata = {1'b0, r_bnoise};
            kabf_pkg::REG_MNOISE: prdata = {1'b0, r_mnoise};
        endcase
    end

    assign pready           = 1'b1;
    assign o_ready          = (r_step == S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_angle_estimate = r_out_angle;
    assign o_rate_estimate  = r_out_rate;
    assign o_bias_estimate  = r_out_bias;

    // A transfer in starts the sequencer, so input closes the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input still open after transfer");

    // A new result only comes from the final step
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(o_valid) && o_valid) |-> $past(r_step == S_DONE))
        else $error("result without finished sample");

    // Shared units never report completion while the sequencer is idle
    a_units_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mdone || w_ddone) |-> (r_step != S_IDLE))
        else $error("unit completion while idle");

endmodule

`default_nettype wire
